@@ hw/rtl/sacc_pkg.sv @@
// package for the set-associative write-back cache controller
`default_nettype none
package sacc_pkg;
    localparam int MAX_SETS     = 256;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_WIDTH   = 32;
    localparam int SET_W        = $clog2(MAX_SETS);
    localparam int WAY_W        = $clog2(MAX_WAYS);
    localparam int AGE_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 4;
    localparam logic [3:0] MAX_IB = 4'(SET_W);
    localparam logic [3:0] MAX_OB = 4'd12;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 3'd4;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;
    // unassigned kind, handled as a data read
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [ADDR_WIDTH-1:0] address;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [2:0]            way;
        logic                  fetch_block;
        logic                  forward_write;
        logic                  evict_dirty;
        logic [ADDR_WIDTH-1:0] evict_addr;
    } resp_t;

    // one way of a set as stored in the set memory
    typedef struct packed {
        logic                  valid;
        logic                  dirty;
        logic [AGE_W-1:0]      age;
        logic [ADDR_WIDTH-1:0] tag;
    } way_ent_t;

    typedef way_ent_t [MAX_WAYS-1:0] set_ent_t;

    typedef struct packed {
        logic [3:0] ib;
        logic [3:0] ob;
        logic [3:0] nw;
        logic       walloc;
        logic       policy;
    } cfg_t;

    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_OUT} state_t;
endpackage
`default_nettype wire

@@ hw/rtl/sacc_set_mem.sv @@
// set memory: one wide entry per set, registered read
`default_nettype none
module sacc_set_mem (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [sacc_pkg::SET_W-1:0] waddr,
    input  wire sacc_pkg::set_ent_t   wdata,
    input  wire logic [sacc_pkg::SET_W-1:0] raddr,
    output sacc_pkg::set_ent_t        rdata
);
    import sacc_pkg::*;
    set_ent_t mem [MAX_SETS];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/sacc_fifo_mem.sv @@
// per-set round robin pointers, registered read
`default_nettype none
module sacc_fifo_mem (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [sacc_pkg::SET_W-1:0] waddr,
    input  wire logic [sacc_pkg::WAY_W-1:0] wdata,
    input  wire logic [sacc_pkg::SET_W-1:0] raddr,
    output logic [sacc_pkg::WAY_W-1:0]      rdata
);
    import sacc_pkg::*;
    logic [WAY_W-1:0] mem [MAX_SETS];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/set_assoc_writeback_cache_ctrl.sv @@
// top level of the set-associative write-back cache controller
//
// usage:
//   req channel (req_valid/req_ready/req) carries one access: kind and byte
//   address. resp channel (resp_valid/resp_ready/resp) returns one result per
//   access: hit, way, fetch_block, forward_write, evict_dirty, evict_addr.
//   cfg_we/cfg_index/cfg_data write the configuration registers at once; write
//   them only while no access is in flight.
// timing:
//   a transfer into the block starts a registered set memory read, then tag
//   compare and victim choice with write-back into the set memory, and the
//   result lands in an output register. a request is taken only while the
//   lookup stage is empty, so the set memory read-modify-write of one access
//   ends before the next access reads its set. the next request is taken
//   while the result waits in the output register.
// reset:
//   a clearing pass walks all 256 sets, one set per cycle,
//   zeroing valid, dirty, age and fifo pointer; req_ready stays low meanwhile.
//   configuration returns to index_bits 0, offset_bits 5, ways_used 1,
//   write_allocate 1, policy lru.
// stall:
//   when resp_ready is low the result holds; one further request can be taken
//   into the lookup stage, and then req_ready drops until the output register is free.
`default_nettype none
module set_assoc_writeback_cache_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire sacc_pkg::req_t                 req,
    output logic                                resp_valid,
    input  wire logic                           resp_ready,
    output sacc_pkg::resp_t                     resp,
    input  wire logic                           cfg_we,
    input  wire logic [sacc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sacc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sacc_pkg::*;

    cfg_t cfg_reg;

    // clearing pass
    logic             clr_busy_reg;
    logic [SET_W-1:0] clr_cnt_reg;

    // lookup stage holds the accepted request while memory reads
    logic        look_reg;
    req_t        lreq_reg;

    // output register
    logic        ovld_reg;
    resp_t       out_reg;

    set_ent_t         rd_set;
    logic [WAY_W-1:0] rd_fp;
    set_ent_t         wr_set;
    logic [WAY_W-1:0] wr_fp;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    logic [SET_W-1:0] mem_raddr;
    logic             fp_we;

    // saturated configuration
    logic [3:0] ib_s;
    logic [3:0] ob_s;
    logic [3:0] nw_s;

    always_comb
    begin
        ib_s = (cfg_reg.ib > MAX_IB) ? MAX_IB : cfg_reg.ib;
        ob_s = (cfg_reg.ob > MAX_OB) ? MAX_OB : cfg_reg.ob;
        nw_s = (cfg_reg.nw == 4'd0) ? 4'd1 :
               ((cfg_reg.nw > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : cfg_reg.nw);
    end

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_WIDTH-1:0] a,
                                                input logic [3:0] ob,
                                                input logic [3:0] ib);
        logic [ADDR_WIDTH-1:0] sh;
        logic [ADDR_WIDTH-1:0] msk;
        sh  = a >> ob;
        msk = ~({ADDR_WIDTH{1'b1}} << ib);
        return SET_W'(sh & msk);
    endfunction

    // a new request is taken once the lookup stage is empty; the lookup
    // itself waits until the output register is or will be free
    logic out_free;
    assign out_free  = !ovld_reg || resp_ready;
    assign req_ready = !clr_busy_reg && !look_reg;

    logic acc;
    assign acc = req_valid && req_ready;
    logic look_done;
    assign look_done = look_reg && out_free;

    // a stalled lookup keeps reading its own set so the read data holds
    assign mem_raddr = look_reg ? set_of(lreq_reg.address, ob_s, ib_s)
                                : set_of(req.address, ob_s, ib_s);

    sacc_set_mem u_set_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_set),
        .raddr (mem_raddr),
        .rdata (rd_set)
    );

    sacc_fifo_mem u_fifo_mem (
        .clk   (clk),
        .we    (fp_we),
        .waddr (mem_waddr),
        .wdata (wr_fp),
        .raddr (mem_raddr),
        .rdata (rd_fp)
    );

    // lookup logic
    logic [SET_W-1:0]      l_set;
    logic [ADDR_WIDTH-1:0] l_tag;
    logic                  l_write;
    logic                  found;
    logic [WAY_W-1:0]      fway;
    logic                  has_free;
    logic [WAY_W-1:0]      free_w;
    logic [WAY_W-1:0]      lru_w;
    logic [WAY_W-1:0]      fifo_w;
    logic [WAY_W-1:0]      victim;
    logic [WAY_W-1:0]      touch_w;
    logic                  do_touch;
    logic                  do_fill;
    resp_t                 res;
    logic [AGE_W-1:0]      touch_age;
    logic [ADDR_WIDTH-1:0] ea;

    always_comb
    begin
        l_set   = set_of(lreq_reg.address, ob_s, ib_s);
        l_tag   = lreq_reg.address >> (5'(ob_s) + 5'(ib_s));
        l_write = (lreq_reg.kind == KIND_WRITE);
        found   = 1'b0;
        fway    = '0;
        has_free = 1'b0;
        free_w  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (4'(w) < nw_s)
            begin
                if (rd_set[w].valid)
                begin
                    if (rd_set[w].tag == l_tag)
                    begin
                        found = 1'b1;
                        fway  = WAY_W'(w);
                    end
                end
                else
                begin
                    has_free = 1'b1;
                    free_w   = WAY_W'(w);
                end
            end
        end
        lru_w = '0;
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (4'(w) < nw_s && rd_set[w].age > rd_set[lru_w].age)
            begin
                lru_w = WAY_W'(w);
            end
        end
        fifo_w = (4'(rd_fp) >= nw_s) ? '0 : rd_fp;
        wr_fp  = (4'(fifo_w) + 4'd1 >= nw_s) ? '0 : fifo_w + WAY_W'(1);

        victim = has_free ? free_w : (cfg_reg.policy ? fifo_w : lru_w);
        res    = '0;
        wr_set = rd_set;
        do_fill = 1'b0;
        fp_we  = 1'b0;
        ea     = (rd_set[victim].tag << (5'(ob_s) + 5'(ib_s)))
               | (ADDR_WIDTH'(l_set) << ob_s);
        if (found)
        begin
            res.hit = 1'b1;
            res.way = 3'(fway);
            if (l_write)
            begin
                wr_set[fway].dirty = 1'b1;
            end
            touch_w = fway;
        end
        else if (l_write && !cfg_reg.walloc)
        begin
            res.forward_write = 1'b1;
            touch_w = '0;
        end
        else
        begin
            do_fill = 1'b1;
            touch_w = victim;
            fp_we   = look_done && !has_free && cfg_reg.policy;
            res.way = 3'(victim);
            res.fetch_block = 1'b1;
            if (rd_set[victim].valid && rd_set[victim].dirty)
            begin
                res.evict_dirty = 1'b1;
                res.evict_addr  = ea;
            end
            wr_set[victim].tag   = l_tag;
            wr_set[victim].valid = 1'b1;
            wr_set[victim].dirty = l_write;
        end
        do_touch  = (found || do_fill) && !cfg_reg.policy;
        touch_age = rd_set[touch_w].age;
        if (do_touch)
        begin
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (4'(v) < nw_s && WAY_W'(v) != touch_w
                    && rd_set[v].age <= touch_age && rd_set[v].age != 3'd7)
                begin
                    wr_set[v].age = rd_set[v].age + 3'd1;
                end
            end
            wr_set[touch_w].age = '0;
        end
        if (clr_busy_reg)
        begin
            wr_set = '0;
            wr_fp  = '0;
            fp_we  = 1'b1;
        end
        mem_we    = clr_busy_reg || look_done;
        mem_waddr = clr_busy_reg ? clr_cnt_reg : l_set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '{ib: 4'd0, ob: 4'd5, nw: 4'd1, walloc: 1'b1, policy: 1'b0};
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            look_reg     <= 1'b0;
            ovld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INDEX_BITS:  cfg_reg.ib     <= cfg_data;
                    CFG_OFFSET_BITS: cfg_reg.ob     <= cfg_data;
                    CFG_WAYS_USED:   cfg_reg.nw     <= cfg_data;
                    CFG_WRITE_ALLOC: cfg_reg.walloc <= cfg_data[0];
                    CFG_POLICY:      cfg_reg.policy <= cfg_data[0];
                    default: ;
                endcase
            end
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(MAX_SETS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (acc)
            begin
                look_reg <= 1'b1;
            end
            else if (look_done)
            begin
                look_reg <= 1'b0;
            end
            if (look_done)
            begin
                ovld_reg <= 1'b1;
            end
            else if (resp_ready)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            lreq_reg <= req;
        end
        if (look_done)
        begin
            out_reg <= res;
        end
    end

    // no set memory write happens while a lookup waits, so re-reading the
    // lookup's set returns the same entry every cycle

    assign resp_valid = ovld_reg;
    assign resp       = out_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !acc)
        else $error("request taken during clearing pass");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ovld_reg && !resp_ready) |=> (ovld_reg && $stable(out_reg)))
        else $error("stalled result changed");
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        look_done |-> $onehot({res.hit, res.fetch_block, res.forward_write}))
        else $error("result flags not exclusive");
`endif
endmodule
`default_nettype wire

@@ tb/cache_checker.sv @@
// checker for the cache controller: predicts each access result and compares
module cache_checker
    import sacc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    input  wire logic                  req_ready,
    input  wire req_t                  req,
    input  wire logic                  resp_valid,
    input  wire logic                  resp_ready,
    input  wire resp_t                 resp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending_count
);
    localparam int NLINES = MAX_SETS * MAX_WAYS;

    logic [ADDR_WIDTH-1:0] line_tag [NLINES];
    logic                  line_valid [NLINES];
    logic                  line_dirty [NLINES];
    logic [2:0]            line_age [NLINES];
    logic [2:0]            rr_ptr [MAX_SETS];
    cfg_t                  shadow_cfg;
    resp_t                 expected_q [$];

    // age update for a touched way
    function automatic void age_touch(int base, int nw, int w);
        logic [2:0] a;
        a = line_age[base + w];
        for (int v = 0; v < nw; v++)
            if (v != w && line_age[base + v] <= a && line_age[base + v] < 3'd7)
                line_age[base + v]++;
        line_age[base + w] = 3'd0;
    endfunction

    function automatic resp_t predict_access(req_t r);
        resp_t o;
        int ib, ob, nw, set_idx, base, found, free_way, victim;
        logic [ADDR_WIDTH-1:0] tag;
        logic [63:0] ea;
        bit is_wr;
        ib = shadow_cfg.ib;
        ob = shadow_cfg.ob;
        nw = shadow_cfg.nw;
        if (ib > SET_W) ib = SET_W;
        if (ob > 12) ob = 12;
        if (nw == 0) nw = 1;
        if (nw > MAX_WAYS) nw = MAX_WAYS;
        is_wr = (r.kind == KIND_WRITE);
        set_idx = int'((r.address >> ob) & ((32'd1 << ib) - 32'd1));
        tag = r.address >> (ob + ib);
        base = set_idx * MAX_WAYS;
        found = -1;
        free_way = -1;
        o = '0;
        for (int w = 0; w < nw; w++)
        begin
            if (line_valid[base + w])
            begin
                if (found < 0 && line_tag[base + w] == tag)
                    found = w;
            end
            else if (free_way < 0)
                free_way = w;
        end
        if (found >= 0)
        begin
            if (is_wr)
                line_dirty[base + found] = 1'b1;
            if (!shadow_cfg.policy)
                age_touch(base, nw, found);
            o.hit = 1'b1;
            o.way = 3'(found);
            return o;
        end
        if (is_wr && !shadow_cfg.walloc)
        begin
            o.forward_write = 1'b1;
            return o;
        end
        if (free_way >= 0)
            victim = free_way;
        else if (!shadow_cfg.policy)
        begin
            victim = 0;
            for (int w = 1; w < nw; w++)
                if (line_age[base + w] > line_age[base + victim])
                    victim = w;
        end
        else
        begin
            victim = rr_ptr[set_idx];
            if (victim >= nw)
                victim = 0;
            rr_ptr[set_idx] = (victim + 1 >= nw) ? 3'd0 : 3'(victim + 1);
        end
        if (line_valid[base + victim] && line_dirty[base + victim])
        begin
            ea = (64'(line_tag[base + victim]) << (ob + ib)) | (64'(set_idx) << ob);
            o.evict_dirty = 1'b1;
            o.evict_addr = ea[31:0];
        end
        line_tag[base + victim] = tag;
        line_valid[base + victim] = 1'b1;
        line_dirty[base + victim] = is_wr;
        if (!shadow_cfg.policy)
            age_touch(base, nw, victim);
        o.way = 3'(victim);
        o.fetch_block = 1'b1;
        return o;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        resp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NLINES; i++)
            begin
                line_tag[i] = '0;
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_age[i] = '0;
            end
            for (int i = 0; i < MAX_SETS; i++)
                rr_ptr[i] = '0;
            shadow_cfg = '{ib: 4'd0, ob: 4'd5, nw: 4'd1, walloc: 1'b1, policy: 1'b0};
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            // result side first: expectations come from earlier transfers
            if (resp_valid && resp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", resp);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (resp.hit !== want.hit || resp.way !== want.way
                        || resp.fetch_block !== want.fetch_block
                        || resp.forward_write !== want.forward_write
                        || resp.evict_dirty !== want.evict_dirty
                        || resp.evict_addr !== want.evict_addr)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, resp);
                    end
                end
            end
            if (req_valid && req_ready)
                expected_q.insert(expected_q.size(), predict_access(req));
            if (cfg_we)
                case (cfg_index)
                    CFG_INDEX_BITS:  shadow_cfg.ib = cfg_data;
                    CFG_OFFSET_BITS: shadow_cfg.ob = cfg_data;
                    CFG_WAYS_USED:   shadow_cfg.nw = cfg_data;
                    CFG_WRITE_ALLOC: shadow_cfg.walloc = cfg_data[0];
                    CFG_POLICY:      shadow_cfg.policy = cfg_data[0];
                    default: ;
                endcase
        end
    end
endmodule

@@ tb/tb_top.sv @@
// top of the cache controller testbench: stimulus, idling phases and verdict
module tb_top;
    import sacc_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  resp_valid;
    logic                  resp_ready = 1'b0;
    resp_t                 resp;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending_count;

    // idle percentages, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, counted down in the receiver process
    int hold_cycles = 0;

    // tag window of the current address pool, kept small so sets refill
    logic [ADDR_WIDTH-1:0] pool_base;
    int                    pool_span;

    always #5 clk = ~clk;

    set_assoc_writeback_cache_ctrl dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .resp_valid(resp_valid), .resp_ready(resp_ready), .resp(resp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cache_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .resp_valid(resp_valid), .resp_ready(resp_ready), .resp(resp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // receiver: random stalls, plus the long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            resp_ready <= 1'b0;
        end
        else
            resp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one transfer into the block; valid stays high across back-to-back items
    task automatic send_access(logic [1:0] k, logic [ADDR_WIDTH-1:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req.kind <= k;
        req.address <= a;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // lowers valid and waits for every outstanding result, then idles before returning
    task automatic drain_all();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(int ib, int ob, int nw, bit walloc, bit pol);
        write_reg(CFG_INDEX_BITS, 4'(ib));
        write_reg(CFG_OFFSET_BITS, 4'(ob));
        write_reg(CFG_WAYS_USED, 4'(nw));
        write_reg(CFG_WRITE_ALLOC, 4'(walloc));
        write_reg(CFG_POLICY, 4'(pol));
    endtask

    // mostly addresses from a small pool of blocks so hits, fills and
    // evictions all occur; sometimes a fully random address
    function automatic logic [ADDR_WIDTH-1:0] pick_address();
        if ($urandom_range(9) == 0)
            return $urandom();
        return pool_base + ($urandom_range(pool_span) << 5) + $urandom_range(31);
    endfunction

    task automatic random_burst(int count);
        logic [1:0] k;
        for (int i = 0; i < count; i++)
        begin
            k = 2'($urandom_range(3));
            send_access(k, pick_address());
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int ph;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset geometry, direct mapped, 32-byte blocks
        send_access(KIND_READ, 32'h0000_0000);
        send_access(KIND_READ, 32'h0000_001F);
        send_access(KIND_WRITE, 32'h0000_0004);
        send_access(KIND_FETCH, 32'hFFFF_FFFF);
        send_access(KIND_RSVD, 32'h0000_0000);
        send_access(KIND_WRITE, 32'hAAAA_AAA0);
        send_access(KIND_READ, 32'h5555_5555);
        drain_all();
        // out-of-range registers saturate; no-allocate write miss
        set_geometry(15, 15, 15, 1'b0, 1'b0);
        send_access(KIND_WRITE, 32'h1234_5678);
        send_access(KIND_READ, 32'hFFFF_FFFF);
        send_access(KIND_WRITE, 32'hFFFF_FFFF);
        send_access(KIND_WRITE, 32'h0000_0000);
        drain_all();
        // ways_used zero acts as one, fifo
        set_geometry(0, 0, 0, 1'b1, 1'b1);
        send_access(KIND_WRITE, 32'h0000_0001);
        send_access(KIND_READ, 32'h0000_0002);
        send_access(KIND_READ, 32'h0000_0001);
        drain_all();
        // unused register index is ignored
        write_reg(3'd7, 4'hF);
        set_geometry(8, 12, 8, 1'b1, 1'b0);
        for (int i = 0; i < 10; i++)
            send_access(KIND_WRITE, 32'(i) << 20);
        drain_all();

        // random phases across geometries and idle patterns
        for (ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (ph == 0)
                set_geometry(0, 5, 1, 1'b1, 1'b0);
            else if (ph == 1)
                set_geometry(8, 12, 8, 1'b0, 1'b1);
            else
                set_geometry($urandom_range(9), $urandom_range(13),
                             $urandom_range(9), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            pool_base = $urandom();
            pool_span = (ph % 2) ? 63 : 15;
            if (ph == 5)
                hold_cycles = 300;
            random_burst(100);
            // pause with everything drained before the next setting
            drain_all();
        end
        drain_all();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/sacc_pkg.sv
hw/rtl/sacc_set_mem.sv
hw/rtl/sacc_fifo_mem.sv
hw/rtl/set_assoc_writeback_cache_ctrl.sv
tb/cache_checker.sv
tb/tb_top.sv
